>>> rtl/core/character_lcd_4bit_controller_assert.svh
// Assertion macros for the character LCD controller.
// Used by the port-level checker; no other dependencies.
`ifndef CHARACTER_LCD_4BIT_CONTROLLER_ASSERT_SVH
`define CHARACTER_LCD_4BIT_CONTROLLER_ASSERT_SVH

// Clocked assertion with synchronous reset disable.
`define LCD4_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define LCD4_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/lcd4_pkg.sv
// Shared types, codes and constants for the character LCD controller.
// No dependencies; imported by the sequencer and the top level.
package lcd4_pkg;

   localparam int TIMER_BITS = 16;

   typedef logic [TIMER_BITS-1:0] timer_type;
   typedef logic [4:0]            step_type;

   localparam step_type STEP_IDLE       = 5'd0;
   localparam step_type STEP_POWER      = 5'd1;
   localparam step_type STEP_INIT_FIRST = 5'd2;
   localparam step_type STEP_INIT_LAST  = 5'd10;
   localparam step_type STEP_USER       = 5'd11;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_INIT   = 2'd1,
      CMD_WRITE  = 2'd2,
      CMD_CURSOR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STROBE_NONE = 2'd0,
      STROBE_HIGH = 2'd1,
      STROBE_LOW  = 2'd2
   } strobe_type;

   typedef enum logic [1:0] {
      REG_POWER_UP_WAIT = 2'd0,
      REG_LONG_WAIT     = 2'd1,
      REG_COMMAND_WAIT  = 2'd2,
      REG_ENABLE_PHASE  = 2'd3
   } reg_index_type;

   localparam logic [15:0] POWER_UP_WAIT_RESET = 16'd50000;
   localparam logic [15:0] LONG_WAIT_RESET     = 16'd5000;
   localparam logic [15:0] COMMAND_WAIT_RESET  = 16'd1000;
   localparam logic [7:0]  ENABLE_PHASE_RESET  = 8'd20;

   localparam logic [3:0] INIT_NIBBLE_ITEMS = 4'd4;

   typedef struct packed {
      logic [15:0] power_up_wait_us;
      logic [15:0] long_wait_us;
      logic [15:0] command_wait_us;
      logic [7:0]  enable_phase_us;
   } cfg_type;

   typedef struct packed {
      logic       rs_pin;
      logic       enable_pin;
      logic [3:0] data_pins;
      logic       busy_res;
      logic       rejected;
   } result_type;

   // init sequence: four wake-up nibbles then five command bytes
   function automatic logic [7:0] init_item(input logic [3:0] k);
      logic [7:0] v;
      unique case (k)
         4'd0:    v = 8'h03;
         4'd1:    v = 8'h03;
         4'd2:    v = 8'h03;
         4'd3:    v = 8'h02;
         4'd4:    v = 8'h28;
         4'd5:    v = 8'h08;
         4'd6:    v = 8'h01;
         4'd7:    v = 8'h06;
         4'd8:    v = 8'h0C;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic timer_type load_timer(input logic [15:0] v);
      logic [TIMER_BITS+15:0] wide;
      wide = {{TIMER_BITS{1'b0}}, v};
      return wide[TIMER_BITS-1:0];
   endfunction

endpackage

>>> rtl/core/character_lcd_4bit_controller.sv
// Top level of the 4-bit character LCD controller: CSR port, sequencer, output stage.
// Depends on lcd4_pkg and lcd4_seq.
//
// One item is accepted every cycle while req_stall is low. Each item (tick or
// request) updates the sequencer state, and its result is registered in the
// output stage that drives the rsp_ side. A two-entry output stage (result
// register plus skid register) lets a new item enter while a result waits;
// req_stall rises only when both entries are full. Timing on the LCD pins is
// counted in tick items, not clock cycles.
module character_lcd_4bit_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_char_code,
   input  logic        req_row,
   input  logic [5:0]  req_col,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_rs_pin,
   output logic        rsp_enable_pin,
   output logic [3:0]  rsp_data_pins,
   output logic        rsp_busy_res,
   output logic        rsp_rejected,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lcd4_pkg::*;

   cfg_type    cfg_ff;
   result_type result;
   result_type main_ff;
   result_type skid_ff;
   logic       main_valid_ff;
   logic       skid_valid_ff;
   logic       accept;
   logic       csr_write;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.power_up_wait_us <= POWER_UP_WAIT_RESET;
         cfg_ff.long_wait_us     <= LONG_WAIT_RESET;
         cfg_ff.command_wait_us  <= COMMAND_WAIT_RESET;
         cfg_ff.enable_phase_us  <= ENABLE_PHASE_RESET;
      end else if (csr_write) begin
         unique case (reg_index_type'(csr_paddr[3:2]))
            REG_POWER_UP_WAIT: cfg_ff.power_up_wait_us <= csr_pwdata[15:0];
            REG_LONG_WAIT:     cfg_ff.long_wait_us     <= csr_pwdata[15:0];
            REG_COMMAND_WAIT:  cfg_ff.command_wait_us  <= csr_pwdata[15:0];
            REG_ENABLE_PHASE:  cfg_ff.enable_phase_us  <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(csr_paddr[3:2]))
         REG_POWER_UP_WAIT: csr_prdata = {16'd0, cfg_ff.power_up_wait_us};
         REG_LONG_WAIT:     csr_prdata = {16'd0, cfg_ff.long_wait_us};
         REG_COMMAND_WAIT:  csr_prdata = {16'd0, cfg_ff.command_wait_us};
         REG_ENABLE_PHASE:  csr_prdata = {24'd0, cfg_ff.enable_phase_us};
         default:           csr_prdata = '0;
      endcase
   end

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~skid_valid_ff;

   lcd4_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cmd       (req_cmd),
      .char_code (req_char_code),
      .row       (req_row),
      .col       (req_col),
      .cfg       (cfg_ff),
      .result    (result)
   );

   // output stage: result register with a skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (!rsp_stall) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (main_valid_ff && rsp_stall) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end else if (!rsp_stall) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (!rsp_stall) main_ff <= skid_ff;
      end else if (accept) begin
         if (main_valid_ff && rsp_stall) skid_ff <= result;
         else                            main_ff <= result;
      end
   end

   assign rsp_valid      = main_valid_ff;
   assign rsp_rs_pin     = main_ff.rs_pin;
   assign rsp_enable_pin = main_ff.enable_pin;
   assign rsp_data_pins  = main_ff.data_pins;
   assign rsp_busy_res   = main_ff.busy_res;
   assign rsp_rejected   = main_ff.rejected;

endmodule

>>> rtl/core/lcd4_seq.sv
// Sequencer state and next-state logic for the character LCD controller.
// Depends on lcd4_pkg; each accepted item updates the state registers.
module lcd4_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          cmd,
   input  logic [7:0]          char_code,
   input  logic                row,
   input  logic [5:0]          col,
   input  lcd4_pkg::cfg_type   cfg,
   output lcd4_pkg::result_type result
);
   import lcd4_pkg::*;

   step_type   step_ff,      step_in;
   strobe_type phase_ff,     phase_in;
   timer_type  timer_ff,     timer_in;
   logic [7:0] byte_hold_ff, byte_hold_in;
   logic       low_next_ff,  low_next_in;
   logic       rs_ff,        rs_in;
   logic       en_ff,        en_in;
   logic [3:0] nibble_ff,    nibble_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         phase_ff     <= STROBE_NONE;
         timer_ff     <= '0;
         byte_hold_ff <= '0;
         low_next_ff  <= 1'b0;
         rs_ff        <= 1'b0;
         en_ff        <= 1'b0;
         nibble_ff    <= '0;
      end else if (accept) begin
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         timer_ff     <= timer_in;
         byte_hold_ff <= byte_hold_in;
         low_next_ff  <= low_next_in;
         rs_ff        <= rs_in;
         en_ff        <= en_in;
         nibble_ff    <= nibble_in;
      end
   end

   always_comb begin
      logic       busy;
      logic       rej;
      logic       nib_start;
      logic [3:0] nib_val;
      logic       byte_start;
      logic [7:0] byte_val;
      logic       item_start;
      logic [3:0] item_k;
      logic [7:0] item_v;
      timer_type  t;

      step_in      = step_ff;
      phase_in     = phase_ff;
      timer_in     = timer_ff;
      byte_hold_in = byte_hold_ff;
      low_next_in  = low_next_ff;
      rs_in        = rs_ff;
      en_in        = en_ff;
      nibble_in    = nibble_ff;
      busy         = (step_ff != STEP_IDLE);
      rej          = 1'b0;
      nib_start    = 1'b0;
      nib_val      = '0;
      byte_start   = 1'b0;
      byte_val     = '0;
      item_start   = 1'b0;
      item_k       = '0;
      t            = timer_ff;

      unique case (cmd_type'(cmd))
         CMD_TICK: begin
            if (busy) begin
               if (t != '0) t = t - TIMER_BITS'(1);
               timer_in = t;
               if (t == '0) begin
                  priority if (step_ff == STEP_POWER) begin
                     step_in    = STEP_INIT_FIRST;
                     item_start = 1'b1;
                     item_k     = '0;
                  end else if (phase_ff == STROBE_HIGH) begin
                     en_in    = 1'b0;
                     phase_in = STROBE_LOW;
                     timer_in = load_timer({8'd0, cfg.enable_phase_us});
                  end else if (phase_ff == STROBE_LOW) begin
                     if (low_next_ff) begin
                        low_next_in = 1'b0;
                        nib_start   = 1'b1;
                        nib_val     = byte_hold_ff[3:0];
                     end else begin
                        phase_in = STROBE_NONE;
                        if (step_ff == STEP_USER) begin
                           step_in  = STEP_IDLE;
                           timer_in = '0;
                        end else if (step_ff == STEP_INIT_FIRST) begin
                           timer_in = load_timer(cfg.long_wait_us);
                        end else begin
                           timer_in = load_timer(cfg.command_wait_us);
                        end
                     end
                  end else if (step_ff >= STEP_INIT_LAST || step_ff < STEP_INIT_FIRST) begin
                     step_in  = STEP_IDLE;
                     timer_in = '0;
                  end else begin
                     step_in    = step_ff + 5'd1;
                     item_start = 1'b1;
                     item_k     = 4'(step_ff - STEP_POWER);
                  end
               end
            end
         end
         CMD_INIT: begin
            if (busy) begin
               rej = 1'b1;
            end else begin
               step_in     = STEP_POWER;
               phase_in    = STROBE_NONE;
               low_next_in = 1'b0;
               rs_in       = 1'b0;
               en_in       = 1'b0;
               timer_in    = load_timer(cfg.power_up_wait_us);
            end
         end
         CMD_WRITE: begin
            if (busy) begin
               rej = 1'b1;
            end else begin
               step_in    = STEP_USER;
               rs_in      = 1'b1;
               byte_start = 1'b1;
               byte_val   = char_code;
            end
         end
         CMD_CURSOR: begin
            if (busy) begin
               rej = 1'b1;
            end else begin
               step_in    = STEP_USER;
               rs_in      = 1'b0;
               byte_start = 1'b1;
               byte_val   = {1'b1, row, col};
            end
         end
         default: ;
      endcase

      item_v = init_item(item_k);
      if (item_start) begin
         if (item_k < INIT_NIBBLE_ITEMS) begin
            low_next_in = 1'b0;
            nib_start   = 1'b1;
            nib_val     = item_v[3:0];
         end else begin
            byte_start = 1'b1;
            byte_val   = item_v;
         end
      end

      if (byte_start) begin
         byte_hold_in = byte_val;
         low_next_in  = 1'b1;
         nib_start    = 1'b1;
         nib_val      = byte_val[7:4];
      end

      if (nib_start) begin
         nibble_in = nib_val;
         en_in     = 1'b1;
         phase_in  = STROBE_HIGH;
         timer_in  = load_timer({8'd0, cfg.enable_phase_us});
      end

      result.rs_pin     = rs_in;
      result.enable_pin = en_in;
      result.data_pins  = nibble_in;
      result.busy_res   = (step_in != STEP_IDLE);
      result.rejected   = rej;
   end

endmodule

>>> rtl/core/lcd4_checker.sv
// Port-level checker for the character LCD controller, bound to the top level.
// Depends on character_lcd_4bit_controller_assert.svh.
`include "character_lcd_4bit_controller_assert.svh"

module lcd4_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_rs_pin,
   input logic       rsp_enable_pin,
   input logic [3:0] rsp_data_pins,
   input logic       rsp_busy_res,
   input logic       rsp_rejected,
   input logic       csr_pready
);

   `LCD4_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable({rsp_rs_pin, rsp_enable_pin, rsp_data_pins, rsp_busy_res, rsp_rejected}), "stalled result changed")
   `LCD4_ASSERT(a_reject_busy, clock, reset, rsp_valid && rsp_rejected |-> rsp_busy_res, "rejected while not busy")
   `LCD4_ASSERT(a_enable_busy, clock, reset, rsp_valid && rsp_enable_pin |-> rsp_busy_res, "enable high while idle")
   `LCD4_ASSERT_ALWAYS(a_pready, clock, csr_pready, "pready low")

endmodule

bind character_lcd_4bit_controller lcd4_checker u_lcd4_checker (.*);

>>> verif/tb_character_lcd_4bit_controller.sv
// Self-checking testbench for character_lcd_4bit_controller; needs lcd4_pkg and the RTL.
// Directed, then random items, each checked against a fixed row or an in-bench sequencer model.
module tb_character_lcd_4bit_controller;
   import lcd4_pkg::*;

   localparam int CYCLE_LIMIT = 200_000;
   localparam int REPORT_CAP  = 50;
   localparam logic [7:0] WAKEUP_BYTES [9] =
      '{8'h03, 8'h03, 8'h03, 8'h02, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] ch;
      logic       row;
      logic [5:0] col;
      logic       fixed;
      result_type want;
   } stim_row;

   // want = {rs, enable, data[3:0], busy, rejected}; timing is enable 1, all waits 0
   localparam stim_row DIRECTED_ROWS [25] = '{
      '{CMD_TICK,   8'h00, 1'b0, 6'd0,  1'b1, 8'b0_0_0000_0_0},
      '{CMD_WRITE,  8'hFF, 1'b0, 6'd0,  1'b1, 8'b1_1_1111_1_0},
      '{CMD_WRITE,  8'h00, 1'b1, 6'd63, 1'b1, 8'b1_1_1111_1_1},
      '{CMD_CURSOR, 8'h00, 1'b1, 6'd63, 1'b1, 8'b1_1_1111_1_1},
      '{CMD_INIT,   8'h00, 1'b0, 6'd0,  1'b1, 8'b1_1_1111_1_1},
      '{CMD_TICK,   8'h00, 1'b0, 6'd0,  1'b1, 8'b1_0_1111_1_0},
      '{CMD_TICK,   8'hFF, 1'b1, 6'd63, 1'b1, 8'b1_1_1111_1_0},
      '{CMD_TICK,   8'h00, 1'b0, 6'd0,  1'b1, 8'b1_0_1111_1_0},
      '{CMD_TICK,   8'h00, 1'b0, 6'd0,  1'b1, 8'b1_0_1111_0_0},
      '{CMD_TICK,   8'hFF, 1'b1, 6'd63, 1'b1, 8'b1_0_1111_0_0},
      '{CMD_CURSOR, 8'h00, 1'b1, 6'd63, 1'b1, 8'b0_1_1111_1_0},
      '{CMD_TICK,   8'h00, 1'b0, 6'd0,  1'b0, 8'h00},
      '{CMD_TICK,   8'h00, 1'b0, 6'd0,  1'b0, 8'h00},
      '{CMD_TICK,   8'h00, 1'b0, 6'd0,  1'b0, 8'h00},
      '{CMD_CURSOR, 8'hFF, 1'b0, 6'd0,  1'b1, 8'b0_0_1111_1_1},
      '{CMD_TICK,   8'h00, 1'b0, 6'd0,  1'b0, 8'h00},
      '{CMD_TICK,   8'h00, 1'b0, 6'd0,  1'b0, 8'h00},
      '{CMD_TICK,   8'h00, 1'b0, 6'd0,  1'b0, 8'h00},
      '{CMD_WRITE,  8'h5A, 1'b0, 6'd21, 1'b0, 8'h00},
      '{CMD_TICK,   8'h00, 1'b0, 6'd0,  1'b0, 8'h00},
      '{CMD_TICK,   8'h00, 1'b0, 6'd0,  1'b0, 8'h00},
      '{CMD_TICK,   8'h00, 1'b0, 6'd0,  1'b0, 8'h00},
      '{CMD_TICK,   8'h00, 1'b0, 6'd0,  1'b0, 8'h00},
      '{CMD_INIT,   8'hA5, 1'b1, 6'd42, 1'b0, 8'h00},
      '{CMD_TICK,   8'h00, 1'b0, 6'd0,  1'b0, 8'h00}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = 2'd0;
   logic [7:0]  req_char_code = 8'd0;
   logic        req_row = 1'b0;
   logic [5:0]  req_col = 6'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_rs_pin;
   logic        rsp_enable_pin;
   logic [3:0]  rsp_data_pins;
   logic        rsp_busy_res;
   logic        rsp_rejected;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   character_lcd_4bit_controller dut (.*);

   always #5 clock = ~clock;

   // sequencer model state
   cfg_type    timing;
   step_type   seq_step;
   strobe_type strobe;
   timer_type  dly;
   logic [7:0] held_byte;
   logic       low_pending;
   logic       rs_q;
   logic       en_q;
   logic [3:0] nib_q;

   result_type expected_pins[$];
   result_type want_pins;
   int cycles;
   int mismatches;
   int rsp_hold;
   int send_max;
   int rsp_max;
   int items_total;
   int items_working;
   int init_runs;
   int refused;
   int csr_writes;

   function automatic void strobe_nibble(input logic [3:0] v);
      nib_q  = v;
      en_q   = 1'b1;
      strobe = STROBE_HIGH;
      dly    = timer_type'(timing.enable_phase_us);
   endfunction

   function automatic void send_byte(input logic [7:0] b);
      held_byte   = b;
      low_pending = 1'b1;
      strobe_nibble(b[7:4]);
   endfunction

   function automatic void send_init_entry(input int k);
      if (k < 4) begin
         low_pending = 1'b0;
         strobe_nibble(WAKEUP_BYTES[k][3:0]);
      end else begin
         send_byte(WAKEUP_BYTES[k]);
      end
   endfunction

   function automatic void next_lcd_action();
      if (seq_step == STEP_POWER) begin
         seq_step = STEP_INIT_FIRST;
         send_init_entry(0);
      end else if (strobe == STROBE_HIGH) begin
         en_q   = 1'b0;
         strobe = STROBE_LOW;
         dly    = timer_type'(timing.enable_phase_us);
      end else if (strobe == STROBE_LOW) begin
         if (low_pending) begin
            low_pending = 1'b0;
            strobe_nibble(held_byte[3:0]);
         end else begin
            strobe = STROBE_NONE;
            if (seq_step == STEP_USER) begin
               seq_step = STEP_IDLE;
               dly      = '0;
            end else begin
               dly = (seq_step == STEP_INIT_FIRST) ? timing.long_wait_us
                                                   : timing.command_wait_us;
            end
         end
      end else if (seq_step >= STEP_INIT_LAST || seq_step < STEP_INIT_FIRST) begin
         seq_step = STEP_IDLE;
         dly      = '0;
      end else begin
         seq_step = seq_step + 5'd1;
         send_init_entry(int'(seq_step - STEP_INIT_FIRST));
      end
   endfunction

   function automatic result_type lcd_model_item(input cmd_type kind, input logic [7:0] ch,
                                                 input logic r, input logic [5:0] c);
      result_type res;
      logic busy;
      busy        = (seq_step != STEP_IDLE);
      res         = '0;
      if (kind == CMD_TICK) begin
         if (busy) begin
            if (dly != '0) dly = dly - 1'b1;
            if (dly == '0) next_lcd_action();
         end
      end else if (busy) begin
         res.rejected = 1'b1;
      end else if (kind == CMD_INIT) begin
         seq_step    = STEP_POWER;
         strobe      = STROBE_NONE;
         low_pending = 1'b0;
         rs_q        = 1'b0;
         en_q        = 1'b0;
         dly         = timing.power_up_wait_us;
      end else begin
         seq_step = STEP_USER;
         rs_q     = (kind == CMD_WRITE);
         send_byte((kind == CMD_WRITE) ? ch : {1'b1, r, c});
      end
      res.rs_pin     = rs_q;
      res.enable_pin = en_q;
      res.data_pins  = nib_q;
      res.busy_res   = (seq_step != STEP_IDLE);
      return res;
   endfunction

   task automatic issue_item(input cmd_type kind, input logic [7:0] ch, input logic r,
                             input logic [5:0] c, input logic fixed, input result_type want);
      int gap;
      logic was_busy;
      result_type predicted;
      gap = $urandom_range(0, send_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= kind;
      req_char_code <= ch;
      req_row       <= r;
      req_col       <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      was_busy  = (seq_step != STEP_IDLE);
      predicted = lcd_model_item(kind, ch, r, c);
      expected_pins.push_back(fixed ? want : predicted);
      items_total++;
      if ((kind == CMD_TICK) ? was_busy : !was_busy) items_working++;
      if (kind == CMD_INIT && !was_busy) init_runs++;
      if (predicted.rejected) refused++;
   endtask

   task automatic tick_until_idle();
      while (seq_step != STEP_IDLE)
         issue_item(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    6'($urandom_range(0, 63)), 1'b0, '0);
   endtask

   task automatic await_quiet();
      req_valid <= 1'b0;
      while (expected_pins.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [15:0] value);
      logic [31:0] word;
      word = $urandom;
      if (idx == REG_ENABLE_PHASE) word[7:0] = value[7:0];
      else word[15:0] = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_POWER_UP_WAIT: timing.power_up_wait_us = value;
         REG_LONG_WAIT:     timing.long_wait_us     = value;
         REG_COMMAND_WAIT:  timing.command_wait_us  = value;
         REG_ENABLE_PHASE:  timing.enable_phase_us  = value[7:0];
      endcase
      csr_writes++;
   endtask

   task automatic apply_timing(input logic [15:0] power, input logic [15:0] long_w,
                               input logic [15:0] cmd_w, input logic [7:0] phase);
      await_quiet();
      csr_write(REG_POWER_UP_WAIT, power);
      csr_write(REG_LONG_WAIT, long_w);
      csr_write(REG_COMMAND_WAIT, cmd_w);
      csr_write(REG_ENABLE_PHASE, {8'h00, phase});
   endtask

   task automatic random_phase(input int quota, input int snd, input int rcv);
      int goal;
      int pause_at;
      int pick;
      cmd_type kind;
      send_max = snd;
      rsp_max  = rcv;
      goal     = items_working + quota;
      pause_at = items_working + quota / 2;
      while (items_working < goal) begin
         if (items_working == pause_at) begin
            await_quiet();
            pause_at = -1;
         end
         pick = $urandom_range(0, 9);
         if (seq_step == STEP_IDLE)
            kind = (pick == 0) ? CMD_TICK : (pick < 3) ? CMD_INIT :
                   (pick < 7) ? CMD_WRITE : CMD_CURSOR;
         else
            kind = (pick == 0) ? cmd_type'($urandom_range(1, 3)) : CMD_TICK;
         issue_item(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    6'($urandom_range(0, 63)), 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  expected_pins.size());
         $display("tb_character_lcd_4bit_controller: FAIL");
         $finish;
      end
   end

   // result side: check each accepted item, then stall for a drawn number of cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pins.size() == 0) begin
               mismatches++;
               $error("result arrived with nothing expected");
            end else begin
               want_pins = expected_pins.pop_front();
               if (rsp_rs_pin !== want_pins.rs_pin || rsp_enable_pin !== want_pins.enable_pin ||
                   rsp_data_pins !== want_pins.data_pins ||
                   rsp_busy_res !== want_pins.busy_res ||
                   rsp_rejected !== want_pins.rejected) begin
                  mismatches++;
                  if (mismatches <= REPORT_CAP) begin
                     if (rsp_rs_pin !== want_pins.rs_pin)
                        $error("rs_pin: expected %0d, got %0d", want_pins.rs_pin, rsp_rs_pin);
                     if (rsp_enable_pin !== want_pins.enable_pin)
                        $error("enable_pin: expected %0d, got %0d", want_pins.enable_pin,
                               rsp_enable_pin);
                     if (rsp_data_pins !== want_pins.data_pins)
                        $error("data_pins: expected %0h, got %0h", want_pins.data_pins,
                               rsp_data_pins);
                     if (rsp_busy_res !== want_pins.busy_res)
                        $error("busy_res: expected %0d, got %0d", want_pins.busy_res,
                               rsp_busy_res);
                     if (rsp_rejected !== want_pins.rejected)
                        $error("rejected: expected %0d, got %0d", want_pins.rejected,
                               rsp_rejected);
                  end
               end
            end
            rsp_hold = $urandom_range(0, rsp_max);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold != 0);
      end
   end

   initial begin
      timing      = '{POWER_UP_WAIT_RESET, LONG_WAIT_RESET, COMMAND_WAIT_RESET,
                      ENABLE_PHASE_RESET};
      seq_step    = STEP_IDLE;
      strobe      = STROBE_NONE;
      dly         = '0;
      held_byte   = '0;
      low_pending = 1'b0;
      rs_q        = 1'b0;
      en_q        = 1'b0;
      nib_q       = '0;
      send_max    = 6;
      rsp_max     = 6;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: fastest timing, then the table
      apply_timing(16'd0, 16'd0, 16'd0, 8'd1);
      for (int i = 0; i < 25; i++)
         issue_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].row,
                    DIRECTED_ROWS[i].col, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);
      tick_until_idle();

      // power-on default timing for one byte, then a full init run at full rate
      apply_timing(POWER_UP_WAIT_RESET, LONG_WAIT_RESET, COMMAND_WAIT_RESET,
                   ENABLE_PHASE_RESET);
      issue_item(CMD_WRITE, 8'($urandom_range(0, 255)), 1'b0, 6'd0, 1'b0, '0);
      tick_until_idle();
      apply_timing(16'd40, 16'd30, 16'd10, 8'd2);
      send_max = 0;
      rsp_max  = 0;
      issue_item(CMD_INIT, 8'h00, 1'b0, 6'd0, 1'b0, '0);
      tick_until_idle();

      // command wait and enable phase are rewritten while the power-up wait runs
      send_max = 6;
      rsp_max  = 6;
      apply_timing(16'd60, 16'd40, 16'd30, 8'd3);
      issue_item(CMD_CURSOR, 8'h00, 1'b1, 6'd5, 1'b0, '0);
      tick_until_idle();
      issue_item(CMD_INIT, 8'h00, 1'b0, 6'd0, 1'b0, '0);
      repeat (5) issue_item(CMD_TICK, 8'h00, 1'b0, 6'd0, 1'b0, '0);
      await_quiet();
      csr_write(REG_COMMAND_WAIT, 16'd2);
      csr_write(REG_ENABLE_PHASE, 16'd1);
      send_max = 0;
      rsp_max  = 0;
      tick_until_idle();

      apply_timing(16'd0, 16'd0, 16'd0, 8'd1);
      random_phase(200, 6, 6);
      apply_timing(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                   16'($urandom_range(0, 6)), 8'($urandom_range(1, 3)));
      random_phase(250, 6, 6);
      apply_timing(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                   16'($urandom_range(0, 6)), 8'($urandom_range(1, 3)));
      random_phase(250, 0, 0);
      apply_timing(16'($urandom_range(0, 10)), 16'($urandom_range(0, 10)),
                   16'($urandom_range(0, 10)), 8'($urandom_range(1, 4)));
      random_phase(225, 6, 0);
      apply_timing(16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
                   16'($urandom_range(0, 20)), 8'($urandom_range(1, 4)));
      random_phase(225, 0, 6);

      await_quiet();
      repeat (8) @(posedge clock);
      $display("Sent %0d items (%0d advanced the sequencer), %0d inits, %0d refused as busy",
               items_total, items_working, init_runs, refused);
      $display("Timing registers written %0d times, zero waits up to power-on defaults",
               csr_writes);
      if (mismatches == 0)
         $display("tb_character_lcd_4bit_controller: PASS");
      else
         $display("tb_character_lcd_4bit_controller: FAIL");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/lcd4_pkg.sv
rtl/core/lcd4_seq.sv
rtl/core/character_lcd_4bit_controller.sv
rtl/core/lcd4_checker.sv
verif/tb_character_lcd_4bit_controller.sv
